[sv/ovn_pkg.sv]
// ----------------------------------------------------------------------------
// ovn_pkg: shared types and constants for the 1D octave value noise block
// Hash constants, fixed-point constants, sequencer state type and the
// elaboration-time cosine weight function used to build the blend ROM.
// ----------------------------------------------------------------------------
package ovn_pkg;

    // Fixed-point constants (Q2.30)
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Integer hash constants, all arithmetic mod 2^32
    localparam int unsigned HASH_SHIFT = 13;
    localparam logic [31:0] HASH_MUL1  = 32'd15731;
    localparam logic [31:0] HASH_ADD1  = 32'd789221;
    localparam logic [31:0] HASH_ADD2  = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] HASH_ONE   = 32'h4000_0000;

    // Blend weight is unsigned Q1.16, 0..65536
    localparam int unsigned WEIGHT_W   = 17;
    localparam logic [63:0] WEIGHT_MAX = 64'd65536;

    // Datapath widths
    localparam int unsigned SMOOTH_W = 34;  // smoothed sums / differences
    localparam int unsigned MUL_W    = 34;  // shared multiplier operands
    localparam int unsigned PROD_W   = 52;  // product bits kept
    localparam int unsigned MIX_W    = 51;  // blended value, Q.48
    localparam int unsigned TOTAL_W  = 36;  // octave sum, Q.32
    localparam int unsigned BLEND_SH = 16;  // base shift of the blend

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_LOAD  = 10'b00_0000_0010,
        ST_HSQ   = 10'b00_0000_0100,
        ST_HMUL  = 10'b00_0000_1000,
        ST_HY    = 10'b00_0001_0000,
        ST_HSUM  = 10'b00_0010_0000,
        ST_BLEND = 10'b00_0100_0000,
        ST_MIX   = 10'b00_1000_0000,
        ST_ACC   = 10'b01_0000_0000,
        ST_SPARE = 10'b10_0000_0000
    } t_state;

    // Blend weight for one ROM angle theta (Q2.30): Taylor cosine to t^20,
    // then w = clamp(round((1 - cos) / 2)) in Q1.16.
    function automatic logic [WEIGHT_W-1:0] cos_weight(input logic [63:0] theta);
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        logic signed [63:0] c;
        logic signed [63:0] num;
        logic signed [63:0] w;
        logic               neg;
        int                 n;
        t   = theta;
        neg = 1'b0;
        if (t > HALF_PI_Q30) begin
            t   = (t > PI_Q30) ? 64'd0 : PI_Q30 - t;
            neg = 1'b1;
        end
        t2   = (t * t) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (n = 1; n <= 10; n++) begin
            prod = (term * t2) >> 30;
            case (n)
                1:       term = prod / 64'd2;
                2:       term = prod / 64'd12;
                3:       term = prod / 64'd30;
                4:       term = prod / 64'd56;
                5:       term = prod / 64'd90;
                6:       term = prod / 64'd132;
                7:       term = prod / 64'd182;
                8:       term = prod / 64'd240;
                9:       term = prod / 64'd306;
                default: term = prod / 64'd380;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        c   = neg ? -sum : sum;
        num = $signed(ONE_Q30) - c;
        if (num < 0) begin
            num = 64'sd0;
        end
        w = (num + 64'sd16384) >>> 15;
        if (w > $signed(WEIGHT_MAX)) begin
            w = $signed(WEIGHT_MAX);
        end
        return w[WEIGHT_W-1:0];
    endfunction

endpackage

[sv/octave_value_noise_1d_top.sv]
// ----------------------------------------------------------------------------
// octave_value_noise_1d_top: 1D hashed value noise summed over octaves
// One position in, one Q2.30 fractal noise value out, computed on a single
// shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_position and pulse start while busy is low; that edge
//   makes the transfer. With octaves to run, busy stays high until the result is out.
//   Output: o_done is high for exactly one cycle with o_noise_value valid;
//   the receiver cannot stall, so the result must be taken that cycle.
//   Config: i_cfg_we writes i_cfg_wdata to octave_count; write only while
//   busy is low. Counts above MAX_OCTAVES act as MAX_OCTAVES.
// Sequence:
//   Each octave runs load, four point hashes on the shared multiplier at
//   3 multiplies each, then hash sum, blend multiply, mix and accumulate.
//   No new start is taken while busy; the next start is taken in the
//   o_done cycle. Zero octaves: result next cycle.
// Reset: synchronous, active low. Idle, o_done low, octave_count 4.
// ----------------------------------------------------------------------------
module octave_value_noise_1d_top #(
    parameter int MAX_OCTAVES       = 8,
    parameter int COS_TABLE_ENTRIES = 256,
    parameter int FRAC_BITS         = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_position,
    // result
    output logic               o_done,
    output logic signed [31:0] o_noise_value,
    // config
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int OW   = $clog2(MAX_OCTAVES + 1);        // octave counter
    localparam int SHW  = $clog2(16 + 2 * MAX_OCTAVES);   // blend shift amount
    localparam int IW   = $clog2(COS_TABLE_ENTRIES);      // ROM index
    localparam int EW   = $clog2(COS_TABLE_ENTRIES + 1);  // entries constant
    localparam int IPW  = FRAC_BITS + EW;                 // index product
    localparam int SCW  = FRAC_BITS + 32;                 // scaled position
    localparam int SW   = ovn_pkg::SMOOTH_W;
    localparam int MW   = ovn_pkg::MUL_W;
    localparam int PW   = ovn_pkg::PROD_W;
    localparam int XW   = ovn_pkg::MIX_W;
    localparam int TW   = ovn_pkg::TOTAL_W;
    localparam int WW   = ovn_pkg::WEIGHT_W;

    // ------------------------------------------------------------------
    // Cosine blend weight ROM, built at elaboration
    // ------------------------------------------------------------------
    logic [WW-1:0] w_rom [COS_TABLE_ENTRIES];

    for (genvar k = 0; k < COS_TABLE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] THETA =
            (ovn_pkg::PI_Q30 * 64'(k)) / 64'(COS_TABLE_ENTRIES);
        assign w_rom[k] = ovn_pkg::cos_weight(THETA);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ovn_pkg::t_state         r_state, n_state;
    logic [3:0]              r_cfg;
    logic [OW-1:0]           r_cnt;      // octaves for this item
    logic [OW-1:0]           r_oct;      // current octave
    logic [1:0]              r_pidx;     // point offset index: p-1 .. p+2
    logic [SCW-1:0]          r_scaled;   // position * 2^octave
    logic [31:0]             r_p;        // floored point, low 32 bits
    logic [IW-1:0]           r_idx;      // ROM index for this octave
    logic [WW-1:0]           r_w;        // registered ROM read
    logic [31:0]             r_y;        // hash pre-mix value
    logic [PW-1:0]           r_prod;     // shared multiplier output
    logic signed [SW-1:0]    r_s1;       // smoothed value at p
    logic signed [SW-1:0]    r_d;        // smoothed(p+1) - smoothed(p)
    logic signed [XW-1:0]    r_mix;      // blended octave, Q.48
    logic signed [TW-1:0]    r_total;    // octave sum, Q.32
    logic                    r_done;
    logic signed [31:0]      r_noise;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                    accept;
    logic [OW-1:0]           cnt_eff;
    logic                    last_oct;
    logic [IPW-1:0]          idx_full;
    logic [31:0]             pt_x;
    logic [31:0]             pt_y;
    logic [31:0]             hash_h;
    logic signed [31:0]      hash_v;
    logic signed [SW-1:0]    hash_vx;
    logic                    do_acc;
    logic [1:0]              acc_idx;
    logic signed [MW-1:0]    mul_a;
    logic signed [MW-1:0]    mul_b;
    logic signed [2*MW-1:0]  mul_full;
    logic [SHW-1:0]          shamt;
    logic signed [XW-1:0]    mix_sh;

    assign accept  = start && (r_state == ovn_pkg::ST_IDLE);
    assign busy    = (r_state != ovn_pkg::ST_IDLE);
    assign cnt_eff = (r_cfg > 4'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES) : OW'(r_cfg);
    assign last_oct = ((r_oct + OW'(1)) == r_cnt);

    // ROM index = floor(frac * entries / 2^FRAC_BITS)
    assign idx_full = IPW'(r_scaled[FRAC_BITS-1:0]) * IPW'(COS_TABLE_ENTRIES);

    // Hash point and its pre-mix
    assign pt_x = r_p + 32'(r_pidx) - 32'd1;
    assign pt_y = (pt_x << ovn_pkg::HASH_SHIFT) ^ pt_x;

    // Final hash step on the last product, mapped to 1 - h/2^30 (Q2.30)
    assign hash_h  = (r_prod[31:0] + ovn_pkg::HASH_ADD2) & ovn_pkg::HASH_MASK;
    assign hash_v  = $signed(ovn_pkg::HASH_ONE - hash_h);
    assign hash_vx = SW'(hash_v);

    // Point hashed last: previous index while the next point squares,
    // point p+2 itself in the hash sum state
    assign do_acc  = (r_state == ovn_pkg::ST_HSUM) ||
                     ((r_state == ovn_pkg::ST_HSQ) && (r_pidx != 2'd0));
    assign acc_idx = (r_state == ovn_pkg::ST_HSUM) ? r_pidx : r_pidx - 2'd1;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ovn_pkg::ST_HSQ: begin
                mul_a = MW'(pt_y);
                mul_b = MW'(pt_y);
            end
            ovn_pkg::ST_HMUL: begin
                mul_a = MW'(r_prod[31:0]);
                mul_b = MW'(ovn_pkg::HASH_MUL1);
            end
            ovn_pkg::ST_HY: begin
                mul_a = MW'(r_y);
                mul_b = MW'(r_prod[31:0] + ovn_pkg::HASH_ADD1);
            end
            ovn_pkg::ST_BLEND: begin
                mul_a = MW'(r_d);
                mul_b = MW'(r_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Octave weight 0.25^i folds into the shift: 16 + 2*i
    assign shamt  = SHW'(ovn_pkg::BLEND_SH) + SHW'({r_oct, 1'b0});
    assign mix_sh = r_mix >>> shamt;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ovn_pkg::ST_IDLE: begin
                if (accept && (cnt_eff != '0)) begin
                    n_state = ovn_pkg::ST_LOAD;
                end
            end
            ovn_pkg::ST_LOAD:  n_state = ovn_pkg::ST_HSQ;
            ovn_pkg::ST_HSQ:   n_state = ovn_pkg::ST_HMUL;
            ovn_pkg::ST_HMUL:  n_state = ovn_pkg::ST_HY;
            ovn_pkg::ST_HY: begin
                n_state = (r_pidx == 2'd3) ? ovn_pkg::ST_HSUM : ovn_pkg::ST_HSQ;
            end
            ovn_pkg::ST_HSUM:  n_state = ovn_pkg::ST_BLEND;
            ovn_pkg::ST_BLEND: n_state = ovn_pkg::ST_MIX;
            ovn_pkg::ST_MIX:   n_state = ovn_pkg::ST_ACC;
            ovn_pkg::ST_ACC: begin
                n_state = last_oct ? ovn_pkg::ST_IDLE : ovn_pkg::ST_LOAD;
            end
            default: n_state = ovn_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovn_pkg::ST_IDLE;
            r_cfg   <= 4'd4;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_oct   <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            // result strobe: zero-octave start, or last accumulate
            r_done <= (accept && (cnt_eff == '0)) ||
                      ((r_state == ovn_pkg::ST_ACC) && last_oct);
            if (accept) begin
                r_cnt <= cnt_eff;
                r_oct <= '0;
            end else if ((r_state == ovn_pkg::ST_ACC) && !last_oct) begin
                r_oct <= r_oct + OW'(1);
            end
            if (r_state == ovn_pkg::ST_LOAD) begin
                r_pidx <= '0;
            end else if ((r_state == ovn_pkg::ST_HY) && (r_pidx != 2'd3)) begin
                r_pidx <= r_pidx + 2'd1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[PW-1:0];
        r_w    <= w_rom[r_idx];

        if (accept) begin
            r_scaled <= SCW'(i_position);
            r_total  <= '0;
        end else if ((r_state == ovn_pkg::ST_ACC) && !last_oct) begin
            r_scaled <= r_scaled << 1;
        end

        if (r_state == ovn_pkg::ST_LOAD) begin
            r_p   <= r_scaled[FRAC_BITS +: 32];
            r_idx <= idx_full[FRAC_BITS +: IW];
            r_s1  <= '0;
            r_d   <= '0;
        end else if (do_acc) begin
            // s1 = v(p-1) + 2v(p) + v(p+1); d = v(p+1) + v(p+2) - v(p) - v(p-1)
            case (acc_idx)
                2'd0: begin
                    r_s1 <= r_s1 + hash_vx;
                    r_d  <= r_d - hash_vx;
                end
                2'd1: begin
                    r_s1 <= r_s1 + (hash_vx <<< 1);
                    r_d  <= r_d - hash_vx;
                end
                2'd2: begin
                    r_s1 <= r_s1 + hash_vx;
                    r_d  <= r_d + hash_vx;
                end
                default: begin
                    r_d  <= r_d + hash_vx;
                end
            endcase
        end

        if (r_state == ovn_pkg::ST_HSQ) begin
            r_y <= pt_y;
        end

        // s1*(65536-w) + s2*w = s1*65536 + d*w
        if (r_state == ovn_pkg::ST_MIX) begin
            r_mix <= $signed({r_s1[SW-1], r_s1, 16'h0000}) + $signed(r_prod[XW-1:0]);
        end

        if ((r_state == ovn_pkg::ST_ACC)) begin
            r_total <= r_total + TW'(mix_sh);
        end

        if (accept && (cnt_eff == '0)) begin
            r_noise <= '0;
        end else if ((r_state == ovn_pkg::ST_ACC) && last_oct) begin
            r_noise <= 32'((r_total + TW'(mix_sh)) >>> 2);
        end
    end

    assign o_done        = r_done;
    assign o_noise_value = r_noise;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cnt_eff != '0)) |=> busy)
        else $error("nonzero octave start did not raise busy");

    a_zero_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cnt_eff == '0)) |=> (o_done && !busy))
        else $error("zero octave start did not return a result at once");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_oct < r_cnt))
        else $error("octave counter past octave count");

    a_blend_pts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ovn_pkg::ST_BLEND) |-> (r_pidx == 2'd3))
        else $error("blend reached before all four points hashed");

endmodule

[sim/octave_value_noise_1d_top_tb.sv]
// ----------------------------------------------------------------------------
// octave_value_noise_1d_top_tb: self-checking bench for the 1D octave noise
// Drives positions through the start/busy command port under several octave
// counts, predicts each fractal noise value with an independent fixed-point
// model and checks every o_done transfer against it in order.
// ----------------------------------------------------------------------------
module octave_value_noise_1d_top_tb;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 2000;  // worst stall: longest send gap plus one 8-octave item
    localparam int DRAIN_CYCLES   = 150;   // one 8-octave item, plus slack
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 125;   // 12 x 125 = 1500 random positions
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic signed [31:0] position;
        logic        [31:0] noise;
    } t_noise_entry;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the octave count, the cosine weight table and the
    // queue of predicted noise values, oldest first.
    // ------------------------------------------------------------------------
    class octave_noise_sb;
        localparam int            OCT_LIMIT = 8;
        localparam int            LUT_SIZE  = 256;
        localparam int            FRAC_W    = 16;
        localparam longint        Q30_ONE   = 64'sd1073741824;
        localparam longint unsigned Q30_PI  = 64'd3373259426;
        localparam longint unsigned Q30_HPI = 64'd1686629713;

        logic [3:0]   octaves;
        longint       weight_lut[LUT_SIZE];
        t_noise_entry expected_noise[$];
        int           errors;

        function new();
            longint unsigned theta;
            longint          num;
            longint          wt;
            octaves = 4'd4;  // reset value
            errors  = 0;
            for (int k = 0; k < LUT_SIZE; k++) begin
                theta = (Q30_PI * longint'(k)) / longint'(LUT_SIZE);
                num   = Q30_ONE - taylor_cos(theta);
                if (num < 0) num = 0;
                wt = (num + 64'sd16384) >>> 15;
                if (wt > 64'sd65536) wt = 64'sd65536;
                weight_lut[k] = wt;
            end
        endfunction

        // cos(t) in Q2.30, Taylor series to t^20, mirrored above pi/2
        function longint taylor_cos(input longint unsigned angle);
            longint unsigned a;
            longint unsigned a2;
            longint unsigned term;
            longint          acc;
            bit              flip;
            a    = angle;
            flip = 1'b0;
            if (a > Q30_HPI) begin
                a    = (a > Q30_PI) ? 64'd0 : Q30_PI - a;
                flip = 1'b1;
            end
            a2   = (a * a) >> 30;
            term = Q30_ONE;
            acc  = Q30_ONE;
            for (int n = 1; n <= 10; n++) begin
                term = ((term * a2) >> 30) / longint'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) acc = acc - longint'(term);
                else            acc = acc + longint'(term);
            end
            return flip ? -acc : acc;
        endfunction

        // point value in Q2.30 from the 32-bit wrapping integer hash
        function longint point_hash(input logic [31:0] x);
            logic [31:0] y;
            logic [31:0] h;
            y = (x << 13) ^ x;
            h = (y * (y * y * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
            return Q30_ONE - $signed({32'd0, h});
        endfunction

        // 1/2, 1/4, 1/4 smoothing, kept in Q.32 units so it stays exact
        function longint smoothed_point(input logic [31:0] p);
            return 2 * point_hash(p) + point_hash(p - 32'd1) + point_hash(p + 32'd1);
        endfunction

        function logic [31:0] predict_noise(input logic signed [31:0] position);
            longint      pos;
            longint      scaled;
            longint      ipart;
            longint      s1;
            longint      s2;
            longint      wt;
            longint      mix;
            longint      total;
            longint      result;
            logic [31:0] p;
            int          idx;
            int          octs;
            pos   = longint'(position);
            octs  = (octaves > OCT_LIMIT) ? OCT_LIMIT : int'(octaves);
            total = 0;
            for (int i = 0; i < octs; i++) begin
                scaled = pos * (64'sd1 << i);
                ipart  = scaled >>> FRAC_W;   // floor, toward minus infinity
                idx    = int'(((scaled & ((64'sd1 << FRAC_W) - 1)) * LUT_SIZE) >>> FRAC_W);
                if (idx >= LUT_SIZE) idx = LUT_SIZE - 1;
                p      = ipart[31:0];          // huge points wrap here
                s1     = smoothed_point(p);
                s2     = smoothed_point(p + 32'd1);
                wt     = weight_lut[idx];
                mix    = s1 * (64'sd65536 - wt) + s2 * wt;
                total  = total + (mix >>> (16 + 2 * i));
            end
            result = total >>> 2;
            return result[31:0];
        endfunction

        function void set_octaves(input logic [3:0] value);
            octaves = value;
        endfunction

        function void note_position(input logic signed [31:0] position);
            t_noise_entry e;
            e.position = position;
            e.noise    = predict_noise(position);
            expected_noise.push_back(e);
        endfunction

        function void check_noise(input logic [31:0] actual);
            t_noise_entry e;
            if (expected_noise.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected noise value %h, nothing pending", actual);
                return;
            end
            e = expected_noise.pop_front();
            if (actual !== e.noise) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("noise mismatch: position %h expected %h got %h",
                             e.position, e.noise, actual);
            end
        endfunction

        function int pending();
            return expected_noise.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic signed [31:0] i_position  = '0;
    logic               o_done;
    logic signed [31:0] o_noise_value;
    logic               i_cfg_we    = 1'b0;
    logic [3:0]         i_cfg_wdata = '0;

    octave_noise_sb sb;
    int             stall_cycles = 0;

    octave_value_noise_1d_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_position    (i_position),
        .o_done        (o_done),
        .o_noise_value (o_noise_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, so the values seen
    // are the ones the DUT registers at that same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // result first: a new start may be taken in the o_done cycle
            if (o_done) sb.check_noise(o_noise_value);
            if (start && !busy) sb.note_position(i_position);
            if (i_cfg_we) sb.set_octaves(i_cfg_wdata);

            // watchdog: cycles with no transfer of any kind
            if (o_done || (start && !busy) || i_cfg_we) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", stall_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; all called and returning on a falling edge
    // ------------------------------------------------------------------------

    // One command transfer. start stays high across back-to-back items so it
    // is never dropped and raised in the same step.
    task automatic send_position(input logic signed [31:0] pos, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Drop start and wait until every predicted value has come back.
    task automatic wait_idle();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0 || busy) @(negedge i_clk);
    endtask

    // Octave count write; only issued with the DUT idle.
    task automatic write_octaves(input logic [3:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random position: full range, near zero, near the range ends, or with
    // the fraction pinned to a table edge.
    function automatic logic signed [31:0] random_position();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: v = ($urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8000_0000)
                   | $urandom_range(0, 16'hffff);
            default: begin
                v = $urandom;
                case ($urandom_range(0, 3))
                    0:       v[15:0] = 16'h0000;
                    1:       v[15:0] = 16'hffff;
                    2:       v[15:0] = 16'hff00;
                    default: v[15:0] = 16'h00ff;
                endcase
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic signed [31:0] directed_pos[] = '{
        32'sh0000_0000,   // point 0: left neighbour wraps to 0xffffffff
        32'sh0000_0001,
        -32'sh0000_0001,  // floor to -1: right neighbours wrap through 0
        32'sh7fff_ffff,   // largest position
        32'sh8000_0000,   // most negative position
        32'sh0001_0000,   // exact integer, weight index 0
        -32'sh0001_0000,
        32'sh0000_ffff,   // top of the fraction, last table entry
        32'sh0000_ff00,
        32'sh0000_8000,   // half way, mid-table weight
        32'sh0000_0100,   // first step into the table
        -32'sh0000_8001,  // negative with non-zero fraction
        32'sh1234_5678
    };

    logic [3:0] phase_octaves[] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd9, 4'd4};

    initial begin
        bit         no_gaps;
        logic [3:0] octs;
        int         gap;

        sb = new();

        // hold synchronous reset, then release it
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed positions at the reset octave count
        foreach (directed_pos[k]) begin
            send_position(directed_pos[k], $urandom_range(0, 3));
        end
        wait_idle();

        // random phases: fixed counts first (extremes and above the limit),
        // then random counts; some phases run back to back with no gaps
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            octs = (ph < phase_octaves.size()) ? phase_octaves[ph]
                                               : 4'($urandom_range(0, 15));
            write_octaves(octs);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                gap = no_gaps ? 0 : $urandom_range(0, 19);
                send_position(random_position(), gap);
            end
            wait_idle();
        end

        // let any stray result show up before judging
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ovn_pkg.sv
sv/octave_value_noise_1d_top.sv
sim/octave_value_noise_1d_top_tb.sv
